// ===== hw/rtl/hsl2rgb_pkg.sv =====
package hsl2rgb_pkg;

   // Fraction bits of the internal fixed point levels.
   localparam int FRAC_BITS = 16;

   // A level of 0.0 to 1.0 needs one integer bit above the fraction.
   localparam int LVL_W = FRAC_BITS + 1;

   // Exact product of the two 9-bit inputs, then re-scaled to the level format.
   localparam int PROD_W  = 17;
   localparam int SCALE_W = 2 * FRAC_BITS + 1;

   // Hue bias: a multiple of 360 that makes every 16-bit hue non-negative.
   localparam int HUE_W = 17;
   localparam logic [HUE_W-1:0] HUE_BIAS = HUE_W'(33120);
   localparam logic [8:0] DEG_360 = 9'd360;
   localparam logic [8:0] DEG_240 = 9'd240;
   localparam logic [8:0] DEG_180 = 9'd180;
   localparam logic [8:0] DEG_120 = 9'd120;
   localparam logic [8:0] DEG_60  = 9'd60;

   // Ramp product and the division by 60, done as a shift by 2 and a
   // multiplication by the rounded-up reciprocal of 15.
   localparam int TP_W        = 6;
   localparam int XP_W        = LVL_W + TP_W;
   localparam int X_W         = FRAC_BITS + 6;
   localparam int Y_W         = X_W - 2;
   localparam int RECIP_SHIFT = Y_W + 4;
   localparam int RECIP_W     = Y_W + 1;
   localparam int MP_W        = Y_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd14) / 64'd15);

   // Segment of the piecewise hue ramp.
   typedef enum logic [1:0] {
      SEG_RISE = 2'd0,
      SEG_HIGH = 2'd1,
      SEG_FALL = 2'd2,
      SEG_LOW  = 2'd3
   } seg_type;

   typedef struct packed {
      seg_type          seg;
      logic [TP_W-1:0]  tp;
   } ramp_type;

   // Classify a channel angle of 0..359 into its ramp segment and ramp step.
   function automatic ramp_type ramp_select(input logic [8:0] t);
      ramp_type   r;
      logic [8:0] fall;
      fall = DEG_240 - t;
      if (t < DEG_60) begin
         r.seg = SEG_RISE;
         r.tp  = t[TP_W-1:0];
      end else if (t < DEG_180) begin
         r.seg = SEG_HIGH;
         r.tp  = '0;
      end else if (t < DEG_240) begin
         r.seg = SEG_FALL;
         r.tp  = fall[TP_W-1:0];
      end else begin
         r.seg = SEG_LOW;
         r.tp  = '0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/hsl_to_rgb_converter_unit.sv =====
// HSL to RGB pixel converter, CSS3 colour algorithm.
// Request channel: req_valid, req_stall and the pixel fields req_hue_degrees
// (signed whole degrees), req_saturation and req_lightness (units of 1/256).
// A request is taken at a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid, rsp_stall and the 8-bit rsp_red, rsp_green
// and rsp_blue; a response is taken when rsp_valid is high and rsp_stall low.
// The block is a six stage pipeline: a request passes the stage registers 1 to
// 6 in turn before it shows on the response ports. One pixel is accepted
// every clock while req_stall is low. The depth is set by the hue modulo
// steps, the level arithmetic, the ramp multiplier and the reciprocal
// multiplier for the division by 60, each with a register stage of its own.
// Reset (synchronous, active high) empties every stage; the first request
// can be taken in the cycle after reset falls.
// While the receiver stalls, the response is held and the stages behind it
// close up any empty slots; req_stall rises only when every stage holds a
// request.
module hsl_to_rgb_converter_unit
   import hsl2rgb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_hue_degrees,
   input  logic        [8:0]  req_saturation,
   input  logic        [8:0]  req_lightness,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic        [7:0]  rsp_red,
   output logic        [7:0]  rsp_green,
   output logic        [7:0]  rsp_blue
);

   // Pipeline control: one valid bit per stage and a ready chain.
   logic [6:1] vld_ff;
   logic [6:1] vld_in;
   logic [6:1] rdy;

   always_comb begin
      rdy[6] = !vld_ff[6] || !rsp_stall;
      rdy[5] = !vld_ff[5] || rdy[6];
      rdy[4] = !vld_ff[4] || rdy[5];
      rdy[3] = !vld_ff[3] || rdy[4];
      rdy[2] = !vld_ff[2] || rdy[3];
      rdy[1] = !vld_ff[1] || rdy[2];
      vld_in = {vld_ff[5:1], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall = !rdy[1];
   assign rsp_valid = vld_ff[6];

   // Stage 1: bias the hue, first four modulo steps, clamp S and L, product L*S.
   logic [12:0]       s1_hue_ff, s1_hue_in;
   logic [8:0]        s1_sc_ff, s1_sc_in;
   logic [8:0]        s1_lc_ff, s1_lc_in;
   logic [PROD_W-1:0] s1_prod_ff, s1_prod_in;
   logic [HUE_W-1:0]  s1_hv;
   logic [17:0]       s1_full;

   always_comb begin
      s1_hv = {req_hue_degrees[15], req_hue_degrees} + HUE_BIAS;
      for (int k = 7; k >= 4; k--) begin
         if (s1_hv >= (HUE_W'(DEG_360) << k)) begin
            s1_hv = s1_hv - (HUE_W'(DEG_360) << k);
         end
      end
      s1_hue_in  = s1_hv[12:0];
      s1_sc_in   = (req_saturation > 9'd256) ? 9'd256 : req_saturation;
      s1_lc_in   = (req_lightness > 9'd256) ? 9'd256 : req_lightness;
      s1_full    = {9'b0, s1_sc_in} * {9'b0, s1_lc_in};
      s1_prod_in = s1_full[PROD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_hue_ff  <= s1_hue_in;
         s1_sc_ff   <= s1_sc_in;
         s1_lc_ff   <= s1_lc_in;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // Stage 2: last four modulo steps, scaled L, S and L*S, and the level m2.
   logic [8:0]         s2_h_ff, s2_h_in;
   logic [LVL_W-1:0]   s2_l_ff, s2_l_in;
   logic [LVL_W-1:0]   s2_m2_ff, s2_m2_in;
   logic [12:0]        s2_hv;
   logic [LVL_W-1:0]   s2_s;
   logic [SCALE_W-1:0] s2_wide;
   logic [LVL_W-1:0]   s2_ls;
   logic [LVL_W:0]     s2_sum;

   always_comb begin
      s2_hv = s1_hue_ff;
      for (int k = 3; k >= 0; k--) begin
         if (s2_hv >= (13'(DEG_360) << k)) begin
            s2_hv = s2_hv - (13'(DEG_360) << k);
         end
      end
      s2_h_in = s2_hv[8:0];
      s2_l_in = {s1_lc_ff, {(FRAC_BITS-8){1'b0}}};
      s2_s    = {s1_sc_ff, {(FRAC_BITS-8){1'b0}}};
      s2_wide = {s1_prod_ff, {(2*FRAC_BITS-16){1'b0}}};
      s2_ls   = s2_wide[SCALE_W-1:FRAC_BITS];
      // Lightness below one half means the top two bits of the raw value are clear.
      if (!s1_lc_ff[8] && !s1_lc_ff[7]) begin
         s2_sum = {1'b0, s2_l_in} + {1'b0, s2_ls};
      end else begin
         s2_sum = {1'b0, s2_l_in} + {1'b0, s2_s} - {1'b0, s2_ls};
      end
      s2_m2_in = s2_sum[LVL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_h_ff  <= s2_h_in;
         s2_l_ff  <= s2_l_in;
         s2_m2_ff <= s2_m2_in;
      end
   end

   // Stage 3: level m1, the ramp height and each channel's segment.
   logic [LVL_W-1:0] s3_m1_ff, s3_m1_in;
   logic [LVL_W-1:0] s3_m2_ff, s3_m2_in;
   logic [LVL_W-1:0] s3_d_ff, s3_d_in;
   seg_type          s3_seg_ff [3];
   seg_type          s3_seg_in [3];
   logic [TP_W-1:0]  s3_tp_ff [3];
   logic [TP_W-1:0]  s3_tp_in [3];
   logic [LVL_W:0]   s3_twol;
   logic [LVL_W:0]   s3_diff;
   logic [8:0]       s3_ang [3];
   logic [8:0]       s3_up;
   ramp_type         s3_ramp [3];

   always_comb begin
      s3_twol = {s2_l_ff, 1'b0};
      s3_diff = s3_twol - {1'b0, s2_m2_ff};
      if ({1'b0, s2_m2_ff} > s3_twol) begin
         s3_m1_in = '0;
      end else begin
         s3_m1_in = s3_diff[LVL_W-1:0];
      end
      s3_m2_in = (s2_m2_ff < s3_m1_in) ? s3_m1_in : s2_m2_ff;
      s3_d_in  = s3_m2_in - s3_m1_in;
      // Channel angles: red leads by a third of a turn, blue trails by one.
      s3_up     = s2_h_ff + DEG_120;
      s3_ang[0] = (s3_up >= DEG_360) ? (s3_up - DEG_360) : s3_up;
      s3_ang[1] = s2_h_ff;
      s3_ang[2] = (s2_h_ff >= DEG_120) ? (s2_h_ff - DEG_120) : (s2_h_ff + DEG_240);
      for (int c = 0; c < 3; c++) begin
         s3_ramp[c]   = ramp_select(s3_ang[c]);
         s3_seg_in[c] = s3_ramp[c].seg;
         s3_tp_in[c]  = s3_ramp[c].tp;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_m1_ff <= s3_m1_in;
         s3_m2_ff <= s3_m2_in;
         s3_d_ff  <= s3_d_in;
         for (int c = 0; c < 3; c++) begin
            s3_seg_ff[c] <= s3_seg_in[c];
            s3_tp_ff[c]  <= s3_tp_in[c];
         end
      end
   end

   // Stage 4: ramp product of the height and the step in degrees.
   logic [LVL_W-1:0] s4_m1_ff;
   logic [LVL_W-1:0] s4_m2_ff;
   seg_type          s4_seg_ff [3];
   logic [X_W-1:0]   s4_x_ff [3];
   logic [X_W-1:0]   s4_x_in [3];
   logic [XP_W-1:0]  s4_full [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s4_full[c] = XP_W'(s3_d_ff) * XP_W'(s3_tp_ff[c]);
         s4_x_in[c] = s4_full[c][X_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_m1_ff <= s3_m1_ff;
         s4_m2_ff <= s3_m2_ff;
         for (int c = 0; c < 3; c++) begin
            s4_seg_ff[c] <= s3_seg_ff[c];
            s4_x_ff[c]   <= s4_x_in[c];
         end
      end
   end

   // Stage 5: divide by 60 as a quarter times the reciprocal of 15.
   logic [LVL_W-1:0] s5_m1_ff;
   logic [LVL_W-1:0] s5_m2_ff;
   seg_type          s5_seg_ff [3];
   logic [LVL_W-1:0] s5_q_ff [3];
   logic [LVL_W-1:0] s5_q_in [3];
   logic [MP_W-1:0]  s5_mp [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         s5_mp[c]   = MP_W'(s4_x_ff[c][X_W-1:2]) * MP_W'(RECIP);
         s5_q_in[c] = s5_mp[c][RECIP_SHIFT +: LVL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_m1_ff <= s4_m1_ff;
         s5_m2_ff <= s4_m2_ff;
         for (int c = 0; c < 3; c++) begin
            s5_seg_ff[c] <= s4_seg_ff[c];
            s5_q_ff[c]   <= s5_q_in[c];
         end
      end
   end

   // Stage 6: pick the level per segment, scale to a byte and clamp.
   logic [7:0]     rsp_byte_ff [3];
   logic [7:0]     rsp_byte_in [3];
   logic [LVL_W:0] s6_lvl [3];
   logic [9:0]     s6_wide [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (s5_seg_ff[c]) inside
            SEG_RISE, SEG_FALL: s6_lvl[c] = {1'b0, s5_m1_ff} + {1'b0, s5_q_ff[c]};
            SEG_HIGH:           s6_lvl[c] = {1'b0, s5_m2_ff};
            SEG_LOW:            s6_lvl[c] = {1'b0, s5_m1_ff};
            default:            s6_lvl[c] = {1'b0, s5_m1_ff};
         endcase
         s6_wide[c]     = s6_lvl[c][LVL_W:FRAC_BITS-8];
         rsp_byte_in[c] = (s6_wide[c][9] || s6_wide[c][8]) ? 8'd255 : s6_wide[c][7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         for (int c = 0; c < 3; c++) begin
            rsp_byte_ff[c] <= rsp_byte_in[c];
         end
      end
   end

   assign rsp_red   = rsp_byte_ff[0];
   assign rsp_green = rsp_byte_ff[1];
   assign rsp_blue  = rsp_byte_ff[2];

`ifndef SYNTHESIS
   // An empty output stage lets the whole pipeline advance.
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while the output stage is empty");

   // Reset leaves every stage empty.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   // The hue modulo leaves an angle below a full turn.
   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (s2_h_ff < DEG_360))
      else $error("hue not wrapped into one turn");

   // Level m2 never lies below m1 once they are ordered.
   a_levels_ordered: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s3_m1_ff <= s3_m2_ff))
      else $error("level m1 above level m2");

   // A stalled response keeps the pipeline behind it full-handed: the stage
   // that feeds the output holds its request.
   a_feed_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && vld_ff[5]) |=> vld_ff[5])
      else $error("request lost behind a stalled response");
`endif

endmodule
